### design/rotation_matrix_to_quaternion_core_macros.svh
// Assertion macros shared by the rotation matrix to quaternion RTL.
`ifndef ROTATION_MATRIX_TO_QUATERNION_CORE_MACROS_SVH
`define ROTATION_MATRIX_TO_QUATERNION_CORE_MACROS_SVH

// Checks that the antecedent implies the consequent in the same cycle.
`define RMQ_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rmq assertion failed");

// Checks that the antecedent implies the consequent in the following cycle.
`define RMQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rmq assertion failed");

`endif

### design/rmq_pkg.sv
// Types and constants shared by the rotation matrix to quaternion block.
`default_nettype none
package rmq_pkg;

  localparam int DATA_WIDTH = 16;
  localparam int FRAC_BITS  = DATA_WIDTH - 2;
  localparam int DIF_W      = DATA_WIDTH + 1;
  localparam int EXT_W      = DATA_WIDTH + 3;
  localparam int MAG_W      = DATA_WIDTH + 2;
  localparam int MSB_W      = $clog2(MAG_W);
  localparam int NORM_MSB   = 27;
  localparam int NORM_W     = NORM_MSB + 1;
  localparam int WIDE_W     = NORM_W + MAG_W;
  localparam int SHIFT_W    = $clog2(WIDE_W);
  localparam int SQ_W       = 2 * NORM_W;
  localparam int SUM_W      = SQ_W + 2;
  localparam int LEN_W      = SUM_W / 2;
  localparam int QUO_W      = FRAC_BITS + 1;
  localparam int NUM_W      = NORM_W + QUO_W;
  localparam int NUM_Q      = 4;

  localparam logic signed [DATA_WIDTH-1:0] Q_ONE = DATA_WIDTH'(1) << FRAC_BITS;

  typedef logic signed [DATA_WIDTH-1:0] elem_t;

  typedef struct packed {
    elem_t elem_r0c0;
    elem_t elem_r1c0;
    elem_t elem_r2c0;
    elem_t elem_r0c1;
    elem_t elem_r1c1;
    elem_t elem_r2c1;
    elem_t elem_r0c2;
    elem_t elem_r1c2;
    elem_t elem_r2c2;
  } in_beat_t;

  typedef struct packed {
    elem_t quat_w;
    elem_t quat_x;
    elem_t quat_y;
    elem_t quat_z;
    logic  degenerate;
  } out_beat_t;

  typedef struct packed {
    logic [NUM_Q-1:0][NORM_W-1:0] nm;
    logic [NUM_Q-1:0]             neg;
    logic                         degen;
  } side_t;

  typedef struct packed {
    logic [NUM_Q-1:0][QUO_W-1:0] quo;
    logic [NUM_Q-1:0]            neg;
    logic                        degen;
  } quo_t;

endpackage
`default_nettype wire

### design/rotation_matrix_to_quaternion_core.sv
// Rotation matrix to unit quaternion converter, top level.
//
// One input beat on in_data carries the nine Q2.14 elements of a 3x3
// rotation matrix; one output beat on out_data carries the unit quaternion
// (w, x, y, z) in Q2.14 and a degenerate flag. A degenerate matrix gives the
// identity quaternion with the flag set. Every input beat yields exactly one
// output beat, in order.
// The block is a fixed pipeline that accepts one beat per clock cycle while in_stall
// is low. Most of its depth lies in the 29-stage square root, which resolves one
// bit per stage, and the 16-stage divider, a preparation stage followed by one
// quotient bit per stage.
// When out_stall holds a result, the next result parks in a one-entry skid
// register and in_stall rises at that same edge; the whole pipeline then holds
// without losing or repeating a beat. in_stall is taken straight from a
// register. Synchronous active-low reset empties the pipeline and the
// output; no clearing pass is needed.
`default_nettype none
`include "rotation_matrix_to_quaternion_core_macros.svh"
module rotation_matrix_to_quaternion_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  rmq_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output rmq_pkg::out_beat_t out_data
);

  localparam int W  = rmq_pkg::DATA_WIDTH;
  localparam int EW = rmq_pkg::EXT_W;
  localparam int DW = rmq_pkg::DIF_W;
  localparam int MW = rmq_pkg::MAG_W;
  localparam int NQ = rmq_pkg::NUM_Q;
  localparam int NW = rmq_pkg::NORM_W;
  localparam int SQ = rmq_pkg::SQ_W;
  localparam int SH = rmq_pkg::SHIFT_W;

  typedef enum logic [1:0] {BR_TRACE, BR_X, BR_Y, BR_Z} branch_t;

  logic en;
  logic out_ready;

  logic               out_valid_r, skid_valid_r;
  rmq_pkg::out_beat_t out_d_r, skid_d_r;

  assign en       = !skid_valid_r;
  assign in_stall = skid_valid_r;

  // Stage 1: sums, differences, branch radicands and branch choice.
  logic                 s1_v_r;
  logic signed [DW-1:0] s1_d21_r, s1_d02_r, s1_d10_r, s1_s01_r, s1_s02_r, s1_s12_r;
  logic signed [EW-1:0] s1_r0_r, s1_r1_r, s1_r2_r, s1_r3_r;
  branch_t              s1_br_r;

  logic signed [EW-1:0] e00, e10, e20, e01, e11, e21, e02, e12, e22, one_e, tr;
  branch_t              br_nxt;

  always_comb begin
    e00   = EW'(in_data.elem_r0c0);
    e10   = EW'(in_data.elem_r1c0);
    e20   = EW'(in_data.elem_r2c0);
    e01   = EW'(in_data.elem_r0c1);
    e11   = EW'(in_data.elem_r1c1);
    e21   = EW'(in_data.elem_r2c1);
    e02   = EW'(in_data.elem_r0c2);
    e12   = EW'(in_data.elem_r1c2);
    e22   = EW'(in_data.elem_r2c2);
    one_e = EW'(rmq_pkg::Q_ONE);
    tr    = e00 + e11 + e22;
    if (tr > 0) begin
      br_nxt = BR_TRACE;
    end else if (e00 > e11 && e00 > e22) begin
      br_nxt = BR_X;
    end else if (e11 > e22) begin
      br_nxt = BR_Y;
    end else begin
      br_nxt = BR_Z;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_d21_r <= DW'(e21 - e12);
      s1_d02_r <= DW'(e02 - e20);
      s1_d10_r <= DW'(e10 - e01);
      s1_s01_r <= DW'(e01 + e10);
      s1_s02_r <= DW'(e02 + e20);
      s1_s12_r <= DW'(e12 + e21);
      s1_r0_r  <= tr + one_e;
      s1_r1_r  <= one_e + e00 - e11 - e22;
      s1_r2_r  <= one_e + e11 - e00 - e22;
      s1_r3_r  <= one_e + e22 - e00 - e11;
      s1_br_r  <= br_nxt;
    end
  end

  // Stage 2: numerator vector selection, magnitudes, signs and the degenerate flag.
  logic                       s2_v_r;
  logic [NQ-1:0][MW-1:0]      s2_mag_r;
  logic [NQ-1:0]              s2_neg_r;
  logic                       s2_degen_r;

  logic signed [EW-1:0] vsel [NQ];
  logic signed [EW-1:0] rsel;
  logic [NQ-1:0][MW-1:0] mag_nxt;
  logic [NQ-1:0]         neg_nxt;

  always_comb begin
    case (s1_br_r)
      BR_TRACE: begin
        rsel    = s1_r0_r;
        vsel[0] = s1_r0_r;
        vsel[1] = EW'(s1_d21_r);
        vsel[2] = EW'(s1_d02_r);
        vsel[3] = EW'(s1_d10_r);
      end
      BR_X: begin
        rsel    = s1_r1_r;
        vsel[0] = EW'(s1_d21_r);
        vsel[1] = s1_r1_r;
        vsel[2] = EW'(s1_s01_r);
        vsel[3] = EW'(s1_s02_r);
      end
      BR_Y: begin
        rsel    = s1_r2_r;
        vsel[0] = EW'(s1_d02_r);
        vsel[1] = EW'(s1_s01_r);
        vsel[2] = s1_r2_r;
        vsel[3] = EW'(s1_s12_r);
      end
      default: begin
        rsel    = s1_r3_r;
        vsel[0] = EW'(s1_d10_r);
        vsel[1] = EW'(s1_s02_r);
        vsel[2] = EW'(s1_s12_r);
        vsel[3] = s1_r3_r;
      end
    endcase
    for (int i = 0; i < NQ; i++) begin
      neg_nxt[i] = vsel[i][EW-1];
      mag_nxt[i] = neg_nxt[i] ? MW'(-vsel[i]) : MW'(vsel[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_mag_r   <= mag_nxt;
      s2_neg_r   <= neg_nxt;
      s2_degen_r <= (rsel <= 0);
    end
  end

  // Stage 3: leading one of the largest magnitude.
  logic                           s3_v_r;
  logic [NQ-1:0][MW-1:0]          s3_mag_r;
  logic [NQ-1:0]                  s3_neg_r;
  logic                           s3_degen_r;
  logic [rmq_pkg::MSB_W-1:0]      s3_msb_r;

  logic [MW-1:0]             mag_or;
  logic [rmq_pkg::MSB_W-1:0] msb_nxt;

  always_comb begin
    mag_or  = '0;
    msb_nxt = '0;
    for (int i = 0; i < NQ; i++) begin
      mag_or = mag_or | s2_mag_r[i];
    end
    for (int b = 0; b < MW; b++) begin
      if (mag_or[b]) begin
        msb_nxt = rmq_pkg::MSB_W'(b);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_mag_r   <= s2_mag_r;
      s3_neg_r   <= s2_neg_r;
      s3_degen_r <= s2_degen_r || (mag_or == '0);
      s3_msb_r   <= msb_nxt;
    end
  end

  // Stage 4: block scaling so the largest magnitude tops out at bit 27.
  logic           s4_v_r;
  rmq_pkg::side_t s4_side_r;

  logic [SH-1:0]                  sh_left, sh_right, msb_ext;
  logic [NQ-1:0][NW-1:0]          nm_nxt;

  always_comb begin
    msb_ext  = SH'(s3_msb_r);
    sh_left  = SH'(rmq_pkg::NORM_MSB) - msb_ext;
    sh_right = msb_ext - SH'(rmq_pkg::NORM_MSB);
    for (int i = 0; i < NQ; i++) begin
      if (msb_ext < SH'(rmq_pkg::NORM_MSB)) begin
        nm_nxt[i] = NW'(rmq_pkg::WIDE_W'(s3_mag_r[i]) << sh_left);
      end else begin
        nm_nxt[i] = NW'(rmq_pkg::WIDE_W'(s3_mag_r[i]) >> sh_right);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_side_r.nm    <= nm_nxt;
      s4_side_r.neg   <= s3_neg_r;
      s4_side_r.degen <= s3_degen_r;
    end
  end

  // Stages 5 to 7: squares and their sum.
  logic                   s5_v_r, s6_v_r, s7_v_r;
  rmq_pkg::side_t         s5_side_r, s6_side_r, s7_side_r;
  logic [NQ-1:0][SQ-1:0]  s5_sq_r;
  logic [SQ:0]            s6_p0_r, s6_p1_r;
  logic [rmq_pkg::SUM_W-1:0] s7_sum_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NQ; i++) begin
        s5_sq_r[i] <= SQ'(s4_side_r.nm[i]) * SQ'(s4_side_r.nm[i]);
      end
      s5_side_r <= s4_side_r;
      s6_p0_r   <= (SQ + 1)'(s5_sq_r[0]) + (SQ + 1)'(s5_sq_r[1]);
      s6_p1_r   <= (SQ + 1)'(s5_sq_r[2]) + (SQ + 1)'(s5_sq_r[3]);
      s6_side_r <= s5_side_r;
      s7_sum_r  <= rmq_pkg::SUM_W'(s6_p0_r) + rmq_pkg::SUM_W'(s6_p1_r);
      s7_side_r <= s6_side_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
      s6_v_r <= 1'b0;
      s7_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_valid;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
      s5_v_r <= s4_v_r;
      s6_v_r <= s5_v_r;
      s7_v_r <= s6_v_r;
    end
  end

  // Length, then each scaled magnitude divided by the length.
  logic                      sq_valid;
  logic [rmq_pkg::LEN_W-1:0] sq_root;
  rmq_pkg::side_t            sq_side;
  logic                      dv_valid;
  rmq_pkg::quo_t             dv_quo;

  rmq_isqrt u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s7_v_r),
    .in_rad    (s7_sum_r),
    .in_side   (s7_side_r),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  rmq_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (sq_valid),
    .in_len    (sq_root),
    .in_side   (sq_side),
    .out_valid (dv_valid),
    .out_quo   (dv_quo)
  );

  // Final stage: signs and the identity for degenerate input.
  logic               fin_v_r;
  rmq_pkg::out_beat_t fin_d_r;
  rmq_pkg::out_beat_t fin_nxt;
  rmq_pkg::elem_t     comp [NQ];

  always_comb begin
    rmq_pkg::elem_t qv;
    for (int i = 0; i < NQ; i++) begin
      qv      = W'(dv_quo.quo[i]);
      comp[i] = dv_quo.neg[i] ? -qv : qv;
    end
    if (dv_quo.degen) begin
      fin_nxt.quat_w     = rmq_pkg::Q_ONE;
      fin_nxt.quat_x     = '0;
      fin_nxt.quat_y     = '0;
      fin_nxt.quat_z     = '0;
      fin_nxt.degenerate = 1'b1;
    end else begin
      fin_nxt.quat_w     = comp[0];
      fin_nxt.quat_x     = comp[1];
      fin_nxt.quat_y     = comp[2];
      fin_nxt.quat_z     = comp[3];
      fin_nxt.degenerate = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_v_r <= 1'b0;
    end else if (en) begin
      fin_v_r <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fin_d_r <= fin_nxt;
    end
  end

  // Output register with a one-entry skid register behind it.
  assign out_ready = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (en) begin
      if (fin_v_r && !out_ready) begin
        skid_valid_r <= 1'b1;
      end
      if (out_ready) begin
        out_valid_r <= fin_v_r;
      end
    end else if (out_ready) begin
      out_valid_r  <= 1'b1;
      skid_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (fin_v_r && !out_ready) begin
        skid_d_r <= fin_d_r;
      end
      if (out_ready) begin
        out_d_r <= fin_d_r;
      end
    end else if (out_ready) begin
      out_d_r <= skid_d_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_d_r;

  `RMQ_ASSERT_IMPLIES(a_skid_behind_output, clk, rst_n, skid_valid_r, out_valid_r)
  `RMQ_ASSERT_NEXT(a_skid_holds_on_stall, clk, rst_n, skid_valid_r && out_stall, skid_valid_r)
  `RMQ_ASSERT_IMPLIES(a_degenerate_identity, clk, rst_n,
    out_valid_r && out_d_r.degenerate,
    out_d_r.quat_w == rmq_pkg::Q_ONE && out_d_r.quat_x == '0 &&
    out_d_r.quat_y == '0 && out_d_r.quat_z == '0)
  `RMQ_ASSERT_IMPLIES(a_unit_range, clk, rst_n, out_valid_r,
    out_d_r.quat_x <= rmq_pkg::Q_ONE && out_d_r.quat_x >= -rmq_pkg::Q_ONE &&
    out_d_r.quat_w <= rmq_pkg::Q_ONE && out_d_r.quat_w >= -rmq_pkg::Q_ONE)

endmodule
`default_nettype wire

### design/rmq_isqrt.sv
// Pipelined integer square root, one result bit per stage, with side data.
`default_nettype none
module rmq_isqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [rmq_pkg::SUM_W-1:0]   in_rad,
  input  rmq_pkg::side_t              in_side,
  output logic                        out_valid,
  output logic [rmq_pkg::LEN_W-1:0]   out_root,
  output rmq_pkg::side_t              out_side
);

  localparam int STAGES = rmq_pkg::LEN_W;
  localparam int SW     = rmq_pkg::SUM_W;

  logic [STAGES-1:0] vld_r;
  logic [SW-1:0]     rad_r  [STAGES];
  logic [SW-1:0]     res_r  [STAGES];
  rmq_pkg::side_t    side_r [STAGES];

  for (genvar k = 0; k < STAGES; k++) begin : g_stage
    localparam int          SH  = 2 * (STAGES - 1 - k);
    localparam logic [SW-1:0] BIT = SW'(1) << SH;

    logic           v_in;
    logic [SW-1:0]  rad_in;
    logic [SW-1:0]  res_in;
    rmq_pkg::side_t s_in;
    logic [SW-1:0]  trial;
    logic [SW-1:0]  rad_nxt;
    logic [SW-1:0]  res_nxt;

    if (k == 0) begin : g_first
      assign v_in   = in_valid;
      assign rad_in = in_rad;
      assign res_in = '0;
      assign s_in   = in_side;
    end else begin : g_next
      assign v_in   = vld_r[k-1];
      assign rad_in = rad_r[k-1];
      assign res_in = res_r[k-1];
      assign s_in   = side_r[k-1];
    end

    always_comb begin
      trial = res_in + BIT;
      if (rad_in >= trial) begin
        rad_nxt = rad_in - trial;
        res_nxt = (res_in >> 1) + BIT;
      end else begin
        rad_nxt = rad_in;
        res_nxt = res_in >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad_r[k]  <= rad_nxt;
        res_r[k]  <= res_nxt;
        side_r[k] <= s_in;
      end
    end
  end

  assign out_valid = vld_r[STAGES-1];
  assign out_root  = rmq_pkg::LEN_W'(res_r[STAGES-1]);
  assign out_side  = side_r[STAGES-1];

endmodule
`default_nettype wire

### design/rmq_div.sv
// Pipelined four-lane restoring divider, one quotient bit per stage.
`default_nettype none
module rmq_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [rmq_pkg::LEN_W-1:0]   in_len,
  input  rmq_pkg::side_t              in_side,
  output logic                        out_valid,
  output rmq_pkg::quo_t               out_quo
);

  localparam int LW = rmq_pkg::LEN_W;
  localparam int QW = rmq_pkg::QUO_W;
  localparam int NQ = rmq_pkg::NUM_Q;
  localparam int NW = rmq_pkg::NUM_W;

  typedef struct packed {
    logic [LW-1:0]          len;
    logic [NQ-1:0][LW-1:0]  rem;
    logic [NQ-1:0][QW-1:0]  low;
    logic [NQ-1:0][QW-1:0]  quo;
    logic [NQ-1:0]          neg;
    logic                   degen;
  } step_t;

  logic [QW:0] vld_r;
  step_t       step_r [QW+1];
  step_t       prep_nxt;

  always_comb begin
    logic [NW-1:0] num;
    prep_nxt       = '0;
    prep_nxt.len   = in_len;
    prep_nxt.neg   = in_side.neg;
    prep_nxt.degen = in_side.degen;
    for (int i = 0; i < NQ; i++) begin
      num = (NW'(in_side.nm[i]) << rmq_pkg::FRAC_BITS) + NW'(in_len >> 1);
      prep_nxt.rem[i] = LW'(num[NW-1:QW]);
      prep_nxt.low[i] = num[QW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      step_r[0] <= prep_nxt;
    end
  end

  for (genvar k = 1; k <= QW; k++) begin : g_step
    step_t step_nxt;

    always_comb begin
      logic [LW:0] rem2;
      step_t       cur;
      cur      = step_r[k-1];
      step_nxt = cur;
      for (int i = 0; i < NQ; i++) begin
        rem2 = {cur.rem[i], cur.low[i][QW-1]};
        step_nxt.low[i] = cur.low[i] << 1;
        if (rem2 >= {1'b0, cur.len}) begin
          step_nxt.rem[i] = LW'(rem2 - {1'b0, cur.len});
          step_nxt.quo[i] = {cur.quo[i][QW-2:0], 1'b1};
        end else begin
          step_nxt.rem[i] = LW'(rem2);
          step_nxt.quo[i] = {cur.quo[i][QW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        step_r[k] <= step_nxt;
      end
    end
  end

  assign out_valid     = vld_r[QW];
  assign out_quo.quo   = step_r[QW].quo;
  assign out_quo.neg   = step_r[QW].neg;
  assign out_quo.degen = step_r[QW].degen;

endmodule
`default_nettype wire

### tb/tb_rotation_matrix_to_quaternion_core.sv
// Self-checking testbench for the rotation matrix to quaternion converter.
module tb_rotation_matrix_to_quaternion_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_CYCLES = 20000;
  localparam int DRAIN_CYCLES = 80;
  localparam int RANDOM_BEATS = 1950;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  rmq_pkg::in_beat_t in_data;
  logic out_valid;
  logic out_stall;
  rmq_pkg::out_beat_t out_data;

  rmq_pkg::out_beat_t quat_queue[$];
  int error_count;
  int idle_cycles;
  bit timed_out;

  typedef struct {
    rmq_pkg::in_beat_t  mat;
    bit                 typed;
    rmq_pkg::out_beat_t quat;
  } stim_row_t;

  stim_row_t directed_rows[$];

  rotation_matrix_to_quaternion_core DUT (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
    .out_data(out_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic rmq_pkg::out_beat_t identity_quat();
    rmq_pkg::out_beat_t q;
    q = '0;
    q.quat_w = rmq_pkg::Q_ONE;
    q.degenerate = 1'b1;
    return q;
  endfunction

  function automatic rmq_pkg::out_beat_t matrix_to_quat(rmq_pkg::in_beat_t m);
    longint a00, a10, a20, a01, a11, a21, a02, a12, a22, tr, r;
    longint v[4];
    longint unsigned mag[4];
    bit neg[4];
    longint unsigned mx, sum, len, q;
    int msb;
    rmq_pkg::out_beat_t res;
    a00 = m.elem_r0c0; a10 = m.elem_r1c0; a20 = m.elem_r2c0;
    a01 = m.elem_r0c1; a11 = m.elem_r1c1; a21 = m.elem_r2c1;
    a02 = m.elem_r0c2; a12 = m.elem_r1c2; a22 = m.elem_r2c2;
    tr = a00 + a11 + a22;
    if (tr > 0) begin
      r = tr + (64'sd1 <<< rmq_pkg::FRAC_BITS);
      v[0] = r; v[1] = a21 - a12; v[2] = a02 - a20; v[3] = a10 - a01;
    end else if (a00 > a11 && a00 > a22) begin
      r = (64'sd1 <<< rmq_pkg::FRAC_BITS) + a00 - a11 - a22;
      v[0] = a21 - a12; v[1] = r; v[2] = a01 + a10; v[3] = a02 + a20;
    end else if (a11 > a22) begin
      r = (64'sd1 <<< rmq_pkg::FRAC_BITS) + a11 - a00 - a22;
      v[0] = a02 - a20; v[1] = a01 + a10; v[2] = r; v[3] = a12 + a21;
    end else begin
      r = (64'sd1 <<< rmq_pkg::FRAC_BITS) + a22 - a00 - a11;
      v[0] = a10 - a01; v[1] = a02 + a20; v[2] = a12 + a21; v[3] = r;
    end
    if (r <= 0) return identity_quat();
    mx = 0;
    for (int i = 0; i < 4; i++) begin
      neg[i] = v[i] < 0;
      mag[i] = neg[i] ? -v[i] : v[i];
      if (mag[i] > mx) mx = mag[i];
    end
    if (mx == 0) return identity_quat();
    msb = 0;
    while (msb < 63 && (mx >> (msb + 1)) != 0) msb++;
    sum = 0;
    for (int i = 0; i < 4; i++) begin
      if (msb < rmq_pkg::NORM_MSB) mag[i] = mag[i] << (rmq_pkg::NORM_MSB - msb);
      else mag[i] = mag[i] >> (msb - rmq_pkg::NORM_MSB);
      sum += mag[i] * mag[i];
    end
    len = int_sqrt(sum);
    if (len == 0) return identity_quat();
    res = '0;
    for (int i = 0; i < 4; i++) begin
      q = ((mag[i] << rmq_pkg::FRAC_BITS) + (len >> 1)) / len;
      if (neg[i]) q = -q;
      case (i)
        0: res.quat_w = q[rmq_pkg::DATA_WIDTH-1:0];
        1: res.quat_x = q[rmq_pkg::DATA_WIDTH-1:0];
        2: res.quat_y = q[rmq_pkg::DATA_WIDTH-1:0];
        default: res.quat_z = q[rmq_pkg::DATA_WIDTH-1:0];
      endcase
    end
    return res;
  endfunction

  function automatic rmq_pkg::in_beat_t make_matrix(int e0, int e1, int e2, int e3,
                                                    int e4, int e5, int e6, int e7,
                                                    int e8);
    rmq_pkg::in_beat_t m;
    m.elem_r0c0 = rmq_pkg::elem_t'(e0);
    m.elem_r1c0 = rmq_pkg::elem_t'(e1);
    m.elem_r2c0 = rmq_pkg::elem_t'(e2);
    m.elem_r0c1 = rmq_pkg::elem_t'(e3);
    m.elem_r1c1 = rmq_pkg::elem_t'(e4);
    m.elem_r2c1 = rmq_pkg::elem_t'(e5);
    m.elem_r0c2 = rmq_pkg::elem_t'(e6);
    m.elem_r1c2 = rmq_pkg::elem_t'(e7);
    m.elem_r2c2 = rmq_pkg::elem_t'(e8);
    return m;
  endfunction

  function automatic rmq_pkg::elem_t near_value(int center);
    return rmq_pkg::elem_t'(center + $signed($urandom_range(0, 2048)) - 1024);
  endfunction

  // Axis rotation shapes, independent c and s, small noise, plus random beats.
  function automatic rmq_pkg::in_beat_t random_matrix();
    rmq_pkg::in_beat_t m;
    int sel;
    int c;
    int s;
    m = '0;
    sel = $urandom_range(0, 9);
    c = $signed($urandom_range(0, 32768)) - 16384;
    s = $signed($urandom_range(0, 32768)) - 16384;
    case (sel)
      0, 1:
        m = make_matrix(16384, 0, 0, 0, c, s, 0, -s, c);
      2, 3:
        m = make_matrix(c, 0, -s, 0, 16384, 0, s, 0, c);
      4, 5:
        m = make_matrix(c, s, 0, -s, c, 0, 0, 0, 16384);
      6:
        m = make_matrix(-16384, 0, 0, 0, -16384, 0, 0, 0, 16384);
      default:
        m = rmq_pkg::in_beat_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
    endcase
    if (sel <= 6) begin
      m.elem_r0c0 = near_value(m.elem_r0c0);
      m.elem_r1c0 = near_value(m.elem_r1c0);
      m.elem_r2c0 = near_value(m.elem_r2c0);
      m.elem_r0c1 = near_value(m.elem_r0c1);
      m.elem_r1c1 = near_value(m.elem_r1c1);
      m.elem_r2c1 = near_value(m.elem_r2c1);
      m.elem_r0c2 = near_value(m.elem_r0c2);
      m.elem_r1c2 = near_value(m.elem_r1c2);
      m.elem_r2c2 = near_value(m.elem_r2c2);
    end
    return m;
  endfunction

  task automatic send_matrix(rmq_pkg::in_beat_t m);
    quat_queue.push_back(matrix_to_quat(m));
    in_data <= m;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic pause_sender(int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      case ((($time / 20) >> 9) % 3)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= ($urandom_range(0, 1) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    rmq_pkg::out_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (quat_queue.size() == 0) begin
        $display("%0t: unexpected beat, actual %p", $time, out_data);
        error_count++;
      end else begin
        want = quat_queue.pop_front();
        if (out_data.quat_w !== want.quat_w) begin
          $display("%0t: quat_w expected %0d actual %0d", $time, want.quat_w,
                   out_data.quat_w);
          error_count++;
        end
        if (out_data.quat_x !== want.quat_x) begin
          $display("%0t: quat_x expected %0d actual %0d", $time, want.quat_x,
                   out_data.quat_x);
          error_count++;
        end
        if (out_data.quat_y !== want.quat_y) begin
          $display("%0t: quat_y expected %0d actual %0d", $time, want.quat_y,
                   out_data.quat_y);
          error_count++;
        end
        if (out_data.quat_z !== want.quat_z) begin
          $display("%0t: quat_z expected %0d actual %0d", $time, want.quat_z,
                   out_data.quat_z);
          error_count++;
        end
        if (out_data.degenerate !== want.degenerate) begin
          $display("%0t: degenerate expected %0b actual %0b", $time,
                   want.degenerate, out_data.degenerate);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_CYCLES && !timed_out) begin
        timed_out = 1'b1;
        $display("tb_rotation_matrix_to_quaternion_core: done, errors");
        $finish;
      end
    end
  end

  task automatic add_row(rmq_pkg::in_beat_t m, bit typed, rmq_pkg::out_beat_t q);
    stim_row_t row;
    row.mat = m;
    row.typed = typed;
    row.quat = q;
    directed_rows.push_back(row);
  endtask

  task automatic build_directed_rows();
    rmq_pkg::out_beat_t ident_ok;
    rmq_pkg::out_beat_t z_axis;
    ident_ok = '0;
    ident_ok.quat_w = rmq_pkg::Q_ONE;
    z_axis = '0;
    z_axis.quat_z = rmq_pkg::Q_ONE;
    add_row(make_matrix(16384, 0, 0, 0, 16384, 0, 0, 0, 16384), 1'b1, ident_ok);
    add_row('0, 1'b0, '0);
    add_row(make_matrix(-32768, 0, 0, 0, -32768, 0, 0, 0, -32768), 1'b1, z_axis);
    add_row(make_matrix(16384, 0, 0, 0, -16384, 0, 0, 0, -16384), 1'b0, '0);
    add_row(make_matrix(-16384, 0, 0, 0, 16384, 0, 0, 0, -16384), 1'b0, '0);
    add_row(make_matrix(-16384, 0, 0, 0, -16384, 0, 0, 0, 16384), 1'b0, '0);
    add_row(make_matrix(0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0);
    add_row(make_matrix(-8192, 0, 0, 0, -8192, 0, 0, 0, -8192), 1'b0, '0);
    add_row(make_matrix(-16384, 0, 0, 0, -16384, 0, 0, 0, -16384), 1'b1, z_axis);
    add_row(make_matrix(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767,
                        32767), 1'b0, '0);
    add_row(make_matrix(-32768, -32768, -32768, -32768, -32768, -32768, -32768,
                        -32768, -32768), 1'b0, '0);
    add_row(make_matrix(0, 32767, -32768, -32768, 0, 32767, 32767, -32768, 0),
            1'b0, '0);
    add_row(make_matrix(0, 16384, 0, -16384, 0, 0, 0, 0, 16384), 1'b0, '0);
    add_row(make_matrix(-1, 0, 0, 0, -1, 0, 0, 0, 1), 1'b0, '0);
    add_row(make_matrix(5000, 3, -7, 9, 5000, 11, -13, 15, 5000), 1'b0, '0);
    add_row(make_matrix(-32768, 0, 0, 0, 32767, 0, 0, 0, 32767), 1'b0, '0);
    add_row(make_matrix(-6000, 32767, 100, -32768, -6000, 200, 300, 400, -6000),
            1'b0, '0);
  endtask

  initial begin
    rmq_pkg::in_beat_t m;
    rmq_pkg::out_beat_t typed_quat;
    int burst;
    int drain_wait;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    error_count = 0;
    idle_cycles = 0;
    timed_out = 1'b0;
    build_directed_rows();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed_rows[i]) begin
      if (directed_rows[i].typed) begin
        typed_quat = matrix_to_quat(directed_rows[i].mat);
        if (typed_quat !== directed_rows[i].quat) begin
          $display("%0t: typed row %0d expected %p actual %p", $time, i,
                   directed_rows[i].quat, typed_quat);
          error_count++;
        end
      end
      send_matrix(directed_rows[i].mat);
    end
    pause_sender(0);
    while (quat_queue.size() != 0) @(posedge clk);
    for (int sent = 0; sent < RANDOM_BEATS; ) begin
      burst = $urandom_range(1, 40);
      for (int k = 0; k < burst && sent < RANDOM_BEATS; k++) begin
        m = random_matrix();
        send_matrix(m);
        sent++;
      end
      if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(1, 12));
    end
    in_valid <= 1'b0;
    while (quat_queue.size() != 0) @(posedge clk);
    drain_wait = 0;
    while (drain_wait < DRAIN_CYCLES) begin
      @(posedge clk);
      drain_wait++;
    end
    if (error_count == 0 && quat_queue.size() == 0) begin
      $display("tb_rotation_matrix_to_quaternion_core: done, clean");
    end else begin
      $display("tb_rotation_matrix_to_quaternion_core: done, errors");
    end
    $finish;
  end

endmodule
